// ===== design/assert_macros.svh =====
// Assertion macros shared by the odometry RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/ddo_pkg.sv =====
// Types and constants for the differential drive odometry block
`default_nettype none
package ddo_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_WHEEL_BASE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_M    = 2'd2;

  localparam logic [15:0] STEP_TIME_RST = 16'd6554;
  localparam logic [15:0] INV_BASE_RST  = 16'd1280;
  localparam logic [19:0] TICKS_RST     = 20'd78229;

  localparam logic signed [27:0] PI_Q13     = 28'sd25736;
  localparam logic [27:0]        TWO_PI_Q13 = 28'd51472;
  localparam logic signed [19:0] PI_Q16      = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;

  localparam logic [3:0] CORDIC_LAST = 4'd15;
  localparam logic [3:0] WRAP_TOP    = 4'd12;
  localparam logic [3:0] MULT_B_LAST = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MULT_A, ST_CORDIC, ST_MULT_B, ST_DRAIN, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_TH1, OP_TH2, OP_X1, OP_X2, OP_Y1, OP_Y2, OP_PATH,
    OP_L1, OP_L2, OP_R1, OP_R2
  } mul_op_t;

  typedef enum logic [1:0] {WR_NONE, WR_POS, WR_NEG} wrap_t;

  typedef struct packed {
    logic       load;
    mul_op_t    mul_op;
    logic       cordic_step;
    logic [3:0] cordic_idx;
    logic       wrap_step;
    logic [3:0] wrap_shift;
    logic       wrap_finish;
    logic       out_load;
  } ddo_cmd_t;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    logic signed [19:0] v;
    unique case (i)
      4'd0:  v = 20'sd51472;
      4'd1:  v = 20'sd30386;
      4'd2:  v = 20'sd16055;
      4'd3:  v = 20'sd8150;
      4'd4:  v = 20'sd4091;
      4'd5:  v = 20'sd2047;
      4'd6:  v = 20'sd1024;
      4'd7:  v = 20'sd512;
      4'd8:  v = 20'sd256;
      4'd9:  v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      4'd15: v = 20'sd2;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/ddo_in_if.sv =====
// Input channel: wheel speeds and distance clear
`default_nettype none
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic               clear_distance;
  modport source (output valid, left_speed, right_speed, clear_distance, input ready);
  modport sink (input valid, left_speed, right_speed, clear_distance, output ready);
endinterface
`default_nettype wire

// ===== design/ddo_out_if.sv =====
// Output channel: pose, path length and encoder counts
`default_nettype none
interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  logic [31:0]        distance_travelled;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  modport source (output valid, pos_x, pos_y, heading, distance_travelled,
                  left_count, right_count, input ready);
  modport sink (input valid, pos_x, pos_y, heading, distance_travelled,
                left_count, right_count, output ready);
endinterface
`default_nettype wire

// ===== design/ddo_ctrl.sv =====
// Sequencing controller for the odometry datapath
`default_nettype none
`include "assert_macros.svh"
module ddo_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output ddo_pkg::ddo_cmd_t cmd
);
  import ddo_pkg::*;

  state_t     state, state_next;
  logic [3:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) state_next = ST_MULT_A;
      end
      ST_MULT_A: begin
        if (cnt == 4'd1) begin
          state_next = ST_CORDIC;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_CORDIC: begin
        if (cnt == CORDIC_LAST) begin
          state_next = ST_MULT_B;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_MULT_B: begin
        if (cnt == MULT_B_LAST) begin
          state_next = ST_DRAIN;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_op   = OP_NONE;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MULT_A: cmd.mul_op = (cnt == 4'd0) ? OP_TH1 : OP_TH2;
      ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        cmd.cordic_idx  = cnt;
        // wrap reduction rides along the rotation count
        cmd.wrap_step   = (cnt >= 4'd1) && (cnt <= WRAP_TOP);
        cmd.wrap_shift  = WRAP_TOP - cnt;
        cmd.wrap_finish = (cnt == WRAP_TOP + 4'd1);
      end
      ST_MULT_B: begin
        unique case (cnt)
          4'd0: cmd.mul_op = OP_X1;
          4'd1: cmd.mul_op = OP_X2;
          4'd2: cmd.mul_op = OP_Y1;
          4'd3: cmd.mul_op = OP_Y2;
          4'd4: cmd.mul_op = OP_PATH;
          4'd5: cmd.mul_op = OP_L1;
          4'd6: cmd.mul_op = OP_L2;
          4'd7: cmd.mul_op = OP_R1;
          4'd8: cmd.mul_op = OP_R2;
          default: cmd.mul_op = OP_NONE;
        endcase
      end
      ST_DRAIN: cmd.mul_op = OP_NONE;
      ST_DONE:  cmd.out_load = !out_valid || out_ready;
      default:  cmd.mul_op = OP_NONE;
    endcase
  end

  `ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.out_load, !out_valid || out_ready)
  `ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == ST_MULT_A)
  `ASSERT_NEXT(a_cordic_to_mult, clk, rst, state == ST_CORDIC && cnt == CORDIC_LAST,
               state == ST_MULT_B)

endmodule
`default_nettype wire

// ===== design/ddo_dp.sv =====
// Datapath: config registers, CORDIC, shared multiplier, heading wrap, accumulators
`default_nettype none
`include "assert_macros.svh"
module ddo_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ddo_pkg::ddo_cmd_t                  cmd,
  input  wire logic                               cfg_write,
  input  wire logic [ddo_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [ddo_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic signed [15:0]                 left_speed,
  input  wire logic signed [15:0]                 right_speed,
  input  wire logic                               clear_distance,
  output logic signed [31:0]                      pos_x,
  output logic signed [31:0]                      pos_y,
  output logic signed [15:0]                      heading,
  output logic [31:0]                             distance_travelled,
  output logic signed [31:0]                      left_count,
  output logic signed [31:0]                      right_count
);
  import ddo_pkg::*;

  logic [15:0] step_time, inv_base;
  logic [19:0] tpm;

  logic signed [16:0] lin, diff;
  logic [16:0]        lin_mag;
  logic [15:0]        l_mag, r_mag;
  logic               l_neg, r_neg;

  logic signed [19:0] cx, cy, cz, x_sh, y_sh, z0, c_val, s_val, at;
  logic               flip;

  logic signed [35:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [56:0] p, p_r29, p_r23, p_r13;
  mul_op_t            p_tag;

  logic [31:0] x_acc, y_acc, path_acc, lt_acc, rt_acc;
  logic [15:0] heading_acc;

  logic [27:0]        w, w_cand;
  wrap_t              wmode;
  logic signed [27:0] t, hd_new;
  logic [32:0]        path_sum;
  logic [31:0]        tick_d;

  assign z0    = {heading_acc[15], heading_acc, 3'b000};
  assign x_sh  = cx >>> cmd.cordic_idx;
  assign y_sh  = cy >>> cmd.cordic_idx;
  assign at    = atan_q16(cmd.cordic_idx);
  assign c_val = flip ? -cx : cx;
  assign s_val = flip ? -cy : cy;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      OP_TH1:  begin mul_a = 36'(diff);           mul_b = {5'b0, inv_base}; end
      OP_TH2, OP_X2, OP_Y2, OP_L1, OP_R1, OP_PATH: begin
        mul_b = {5'b0, step_time};
        unique case (cmd.mul_op)
          OP_L1:   mul_a = {20'b0, l_mag};
          OP_R1:   mul_a = {20'b0, r_mag};
          OP_PATH: mul_a = {19'b0, lin_mag};
          default: mul_a = p[35:0];
        endcase
      end
      OP_X1:   begin mul_a = 36'(lin); mul_b = 21'(c_val); end
      OP_Y1:   begin mul_a = 36'(lin); mul_b = 21'(s_val); end
      OP_L2, OP_R2: begin mul_a = p[35:0]; mul_b = {1'b0, tpm}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign p_r29 = p + 57'sd268435456;
  assign p_r23 = p + 57'sd4194304;
  assign p_r13 = p + 57'sd4096;
  assign t     = 28'(signed'(heading_acc)) + 28'(signed'(p_r23[49:23]));
  assign path_sum = {1'b0, path_acc} + {12'b0, p_r13[33:13]};
  assign tick_d   = {15'b0, p[52:36]};
  assign w_cand   = TWO_PI_Q13 << cmd.wrap_shift;

  always_comb begin
    unique case (wmode)
      WR_POS:  hd_new = signed'(w) - PI_Q13 + 28'sd1;
      WR_NEG:  hd_new = PI_Q13 - 28'sd1 - signed'(w);
      default: hd_new = signed'(w);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time   <= STEP_TIME_RST;
      inv_base    <= INV_BASE_RST;
      tpm         <= TICKS_RST;
      p_tag       <= OP_NONE;
      x_acc       <= '0;
      y_acc       <= '0;
      path_acc    <= '0;
      lt_acc      <= '0;
      rt_acc      <= '0;
      heading_acc <= '0;
      wmode       <= WR_NONE;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_STEP_TIME:      step_time <= cfg_data[15:0];
          REG_INV_WHEEL_BASE: inv_base  <= cfg_data[15:0];
          REG_TICKS_PER_M:    tpm       <= cfg_data;
          default: ;
        endcase
      end
      p_tag <= cmd.mul_op;
      if (cmd.load && clear_distance) path_acc <= '0;
      unique case (p_tag)
        OP_TH2: begin
          if (t > PI_Q13) begin
            w     <= unsigned'(t - PI_Q13 - 28'sd1);
            wmode <= WR_POS;
          end else if (t < -PI_Q13) begin
            w     <= unsigned'(-PI_Q13 - t - 28'sd1);
            wmode <= WR_NEG;
          end else begin
            w     <= unsigned'(t);
            wmode <= WR_NONE;
          end
        end
        OP_X2:   x_acc <= x_acc + {{4{p_r29[56]}}, p_r29[56:29]};
        OP_Y2:   y_acc <= y_acc + {{4{p_r29[56]}}, p_r29[56:29]};
        OP_PATH: path_acc <= path_sum[32] ? 32'hFFFF_FFFF : path_sum[31:0];
        OP_L2:   lt_acc <= l_neg ? lt_acc - tick_d : lt_acc + tick_d;
        OP_R2:   rt_acc <= r_neg ? rt_acc - tick_d : rt_acc + tick_d;
        default: ;
      endcase
      if (cmd.wrap_step && wmode != WR_NONE && w >= w_cand) w <= w - w_cand;
      if (cmd.wrap_finish) heading_acc <= hd_new[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != OP_NONE) p <= mul_a * mul_b;
    if (cmd.load) begin
      lin     <= 17'(left_speed) + 17'(right_speed);
      diff    <= 17'(right_speed) - 17'(left_speed);
      lin_mag <= (17'(left_speed) + 17'(right_speed)) < 0
                 ? unsigned'(-(17'(left_speed) + 17'(right_speed)))
                 : unsigned'(17'(left_speed) + 17'(right_speed));
      l_neg   <= left_speed[15];
      r_neg   <= right_speed[15];
      l_mag   <= left_speed[15] ? unsigned'(-left_speed) : unsigned'(left_speed);
      r_mag   <= right_speed[15] ? unsigned'(-right_speed) : unsigned'(right_speed);
      cx      <= CORDIC_GAIN;
      cy      <= '0;
      if (z0 > HALF_PI_Q16) begin
        cz   <= z0 - PI_Q16;
        flip <= 1'b1;
      end else if (z0 < -HALF_PI_Q16) begin
        cz   <= z0 + PI_Q16;
        flip <= 1'b1;
      end else begin
        cz   <= z0;
        flip <= 1'b0;
      end
    end else if (cmd.cordic_step) begin
      if (cz >= 20'sd0) begin
        cx <= cx - y_sh;
        cy <= cy + x_sh;
        cz <= cz - at;
      end else begin
        cx <= cx + y_sh;
        cy <= cy - x_sh;
        cz <= cz + at;
      end
    end
    if (cmd.out_load) begin
      pos_x              <= x_acc;
      pos_y              <= y_acc;
      heading            <= heading_acc;
      distance_travelled <= path_acc;
      left_count         <= lt_acc;
      right_count        <= rt_acc;
    end
  end

  `ASSERT_IMPL(a_heading_range, clk, rst, 1'b1,
               signed'(heading_acc) <= 16'sd25736 && signed'(heading_acc) >= -16'sd25736)
  `ASSERT_IMPL(a_wrap_reduced, clk, rst, cmd.wrap_finish && wmode != WR_NONE,
               w < TWO_PI_Q13)

endmodule
`default_nettype wire

// ===== design/diff_drive_odometry.sv =====
// Top level of the differential drive dead-reckoning odometry block
// One tick is in flight at a time: a new input transaction is accepted only when idle,
// after the previous tick has run the 16-step CORDIC rotation and eleven passes through
// the shared multiplier and its result has been loaded into the output register.
// A finished result waits in the output register while the next tick is accepted.
// Reset (synchronous, rst high) zeroes the pose, path and counts and loads default config.
`default_nettype none
module diff_drive_odometry (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [ddo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ddo_pkg::CFG_DATA_W-1:0]  cfg_data,
  ddo_in_if.sink                               in_ch,
  ddo_out_if.source                            out_ch
);
  import ddo_pkg::*;

  ddo_cmd_t cmd;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  ddo_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .left_speed         (in_ch.left_speed),
    .right_speed        (in_ch.right_speed),
    .clear_distance     (in_ch.clear_distance),
    .pos_x              (out_ch.pos_x),
    .pos_y              (out_ch.pos_y),
    .heading            (out_ch.heading),
    .distance_travelled (out_ch.distance_travelled),
    .left_count         (out_ch.left_count),
    .right_count        (out_ch.right_count)
  );

endmodule
`default_nettype wire
